// ===== sv/tcsc_pkg.sv =====
// shared types, constants and round functions for the tcp sequence chacha20 xor core
package tcsc_pkg;

    localparam int ROUNDS     = 20;
    localparam int NUM_ROUNDS = ((ROUNDS + 1) / 2) * 2;
    localparam int RND_W      = $clog2(NUM_ROUNDS);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int HASH_STEPS = 14;

    localparam logic [31:0] TUPLE_TAG = 32'h4e4c3454;
    localparam logic [31:0] SEED0     = 32'h6e6c3461;
    localparam logic [31:0] SEED1     = 32'h6e6c3462;
    localparam logic [31:0] SEED2     = 32'h6e6c3463;
    localparam logic [31:0] HASH_INIT = 32'hdeadbeef + 32'd20;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [1:0] REG_KEY_0_1 = 2'd0;
    localparam logic [1:0] REG_KEY_2_3 = 2'd1;
    localparam logic [1:0] REG_KEY_4_5 = 2'd2;
    localparam logic [1:0] REG_KEY_6_7 = 2'd3;

    typedef logic [15:0][31:0] cstate_t;
    typedef logic [3:0][63:0] key_t;

    typedef struct packed {
        logic [31:0] seq_number;
        logic [7:0]  protocol;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic        first;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } hash_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } bstate_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // one step of the lookup3 mix and final sequence for five words
    function automatic hash_t hash_step(input hash_t h, input logic [31:0] k3,
                                        input logic [31:0] k4, input logic [3:0] step);
        hash_t r;
        r = h;
        case (step)
            4'd0:  begin r.a = (h.a - h.c) ^ rotl32(h.c, 4);  r.c = h.c + h.b; end
            4'd1:  begin r.b = (h.b - h.a) ^ rotl32(h.a, 6);  r.a = h.a + h.c; end
            4'd2:  begin r.c = (h.c - h.b) ^ rotl32(h.b, 8);  r.b = h.b + h.a; end
            4'd3:  begin r.a = (h.a - h.c) ^ rotl32(h.c, 16); r.c = h.c + h.b; end
            4'd4:  begin r.b = (h.b - h.a) ^ rotl32(h.a, 19); r.a = h.a + h.c; end
            4'd5:  begin r.c = (h.c - h.b) ^ rotl32(h.b, 4);  r.b = h.b + h.a; end
            4'd6:  begin r.b = h.b + k4; r.a = h.a + k3; end
            4'd7:  r.c = (h.c ^ h.b) - rotl32(h.b, 14);
            4'd8:  r.a = (h.a ^ h.c) - rotl32(h.c, 11);
            4'd9:  r.b = (h.b ^ h.a) - rotl32(h.a, 25);
            4'd10: r.c = (h.c ^ h.b) - rotl32(h.b, 16);
            4'd11: r.a = (h.a ^ h.c) - rotl32(h.c, 4);
            4'd12: r.b = (h.b ^ h.a) - rotl32(h.a, 14);
            4'd13: r.c = (h.c ^ h.b) - rotl32(h.b, 24);
            default: r = h;
        endcase
        return r;
    endfunction

    // one column or diagonal round, four quarter rounds side by side
    function automatic cstate_t chacha_round(input cstate_t x, input logic diag);
        cstate_t     r;
        int          ib;
        int          ic;
        int          id;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        r = x;
        for (int i = 0; i < 4; i++) begin
            ib = 4 + (diag ? ((i + 1) & 3) : i);
            ic = 8 + (diag ? ((i + 2) & 3) : i);
            id = 12 + (diag ? ((i + 3) & 3) : i);
            a = x[i];
            b = x[ib];
            c = x[ic];
            d = x[id];
            a = a + b; d = rotl32(d ^ a, 16);
            c = c + d; b = rotl32(b ^ c, 12);
            a = a + b; d = rotl32(d ^ a, 8);
            c = c + d; b = rotl32(b ^ c, 7);
            r[i]  = a;
            r[ib] = b;
            r[ic] = c;
            r[id] = d;
        end
        return r;
    endfunction

endpackage

// ===== sv/tcsc_front.sv =====
// input side: accepts words into a short queue ahead of the keystream sequencer
module tcsc_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tcsc_pkg::item_t  in_item,
    output logic             in_ready,
    input  logic             pop,
    output tcsc_pkg::item_t  head_item,
    output tcsc_pkg::qstat_t stat
);

    tcsc_pkg::item_t                  mem_reg [tcsc_pkg::QDEPTH];
    logic [tcsc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [tcsc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [tcsc_pkg::QCNT_W-1:0]      count_reg;
    logic                             push;
    logic                             do_pop;

    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == tcsc_pkg::QCNT_W'(tcsc_pkg::QDEPTH));
    assign in_ready   = !stat.full;
    assign push       = in_valid && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + tcsc_pkg::QCNT_W'(push) - tcsc_pkg::QCNT_W'(do_pop);
        end
    end

endmodule

// ===== sv/tcsc_back.sv =====
// back side: nonce hash, one-round-per-cycle chacha block and byte xor
module tcsc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  tcsc_pkg::key_t   key,
    input  tcsc_pkg::qstat_t qstat,
    input  tcsc_pkg::item_t  head_item,
    output logic             pop,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    input  logic             out_ready
);

    tcsc_pkg::bstate_t            state_reg, state_next;
    tcsc_pkg::item_t              item_reg, item_next;
    tcsc_pkg::hash_t [2:0]        hash_reg, hash_next;
    logic [3:0]                   step_reg, step_next;
    logic [tcsc_pkg::RND_W-1:0]   rnd_reg, rnd_next;
    logic [31:0]                  counter_reg, counter_next;
    logic [2:0][31:0]             nonce_reg, nonce_next;
    logic [5:0]                   offset_reg, offset_next;
    tcsc_pkg::cstate_t            x_reg, x_next;
    tcsc_pkg::cstate_t            init_reg, init_next;
    tcsc_pkg::cstate_t            ks_reg, ks_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic [31:0]                  ks_word;
    logic [7:0]                   ks_byte;
    logic [31:0]                  k0;
    logic [31:0]                  k1;
    logic [31:0]                  k2;
    tcsc_pkg::cstate_t            init_words;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign ks_word   = ks_reg[offset_reg[5:2]];
    assign ks_byte   = ks_word[{offset_reg[1:0], 3'b000} +: 8];

    assign k0 = head_item.src_addr;
    assign k1 = head_item.dst_addr;
    assign k2 = {head_item.src_port, head_item.dst_port};

    always_comb
    begin
        init_words[0] = tcsc_pkg::SIGMA0;
        init_words[1] = tcsc_pkg::SIGMA1;
        init_words[2] = tcsc_pkg::SIGMA2;
        init_words[3] = tcsc_pkg::SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init_words[4 + 2 * i] = key[i][31:0];
            init_words[5 + 2 * i] = key[i][63:32];
        end
        init_words[12] = counter_reg;
        init_words[13] = nonce_reg[0];
        init_words[14] = nonce_reg[1];
        init_words[15] = nonce_reg[2];
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        hash_next      = hash_reg;
        step_next      = step_reg;
        rnd_next       = rnd_reg;
        counter_next   = counter_reg;
        nonce_next     = nonce_reg;
        offset_next    = offset_reg;
        x_next         = x_reg;
        init_next      = init_reg;
        ks_next        = ks_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        pop            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tcsc_pkg::ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop       = 1'b1;
                    item_next = head_item;
                    step_next = '0;
                    hash_next[0] = '{a: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED0 + k0,
                                     b: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED0 + k1,
                                     c: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED0 + k2};
                    hash_next[1] = '{a: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED1 + k0,
                                     b: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED1 + k1,
                                     c: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED1 + k2};
                    hash_next[2] = '{a: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED2 + k0,
                                     b: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED2 + k1,
                                     c: tcsc_pkg::HASH_INIT + tcsc_pkg::SEED2 + k2};
                    if (head_item.first)
                    begin
                        state_next = tcsc_pkg::ST_HASH;
                    end
                    else if (offset_reg == '0)
                    begin
                        state_next = tcsc_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = tcsc_pkg::ST_EMIT;
                    end
                end
            end
            tcsc_pkg::ST_HASH:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    hash_next[i] = tcsc_pkg::hash_step(hash_reg[i],
                                                       {24'd0, item_reg.protocol},
                                                       tcsc_pkg::TUPLE_TAG, step_reg);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(tcsc_pkg::HASH_STEPS - 1))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        nonce_next[i] = hash_next[i].c;
                    end
                    counter_next = {6'd0, item_reg.seq_number[31:6]};
                    offset_next  = item_reg.seq_number[5:0];
                    state_next   = tcsc_pkg::ST_LOAD;
                end
            end
            tcsc_pkg::ST_LOAD:
            begin
                x_next     = init_words;
                init_next  = init_words;
                rnd_next   = '0;
                state_next = tcsc_pkg::ST_ROUND;
            end
            tcsc_pkg::ST_ROUND:
            begin
                x_next   = tcsc_pkg::chacha_round(x_reg, rnd_reg[0]);
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == tcsc_pkg::RND_W'(tcsc_pkg::NUM_ROUNDS - 1))
                begin
                    state_next = tcsc_pkg::ST_FINAL;
                end
            end
            tcsc_pkg::ST_FINAL:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    ks_next[i] = x_reg[i] + init_reg[i];
                end
                counter_next = counter_reg + 32'd1;
                state_next   = tcsc_pkg::ST_EMIT;
            end
            tcsc_pkg::ST_EMIT:
            begin
                // load the output register once its word has left
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = item_reg.data_byte ^ ks_byte;
                    offset_next    = offset_reg + 1'b1;
                    state_next     = tcsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcsc_pkg::ST_IDLE;
            counter_reg   <= '0;
            nonce_reg     <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            rnd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            nonce_reg     <= nonce_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            rnd_reg       <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        hash_reg     <= hash_next;
        x_reg        <= x_next;
        init_reg     <= init_next;
        ks_reg       <= ks_next;
        out_byte_reg <= out_byte_next;
    end

endmodule

// ===== sv/tcp_seq_chacha20_stream_xor_core.sv =====
// top level of the tcp sequence chacha20 keystream xor core
//
// input words arrive on s_tvalid/s_tready/s_tdata/s_tuser, one payload byte each;
// s_tuser high marks the first byte of a packet, whose tuple and sequence number
// in s_tdata set the nonce (lookup3 hash), block counter and byte position.
// each result word leaves on m_tvalid/m_tready/m_tdata as the byte xor keystream.
// key words are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while the core is idle, which the core does not enforce. a four-word
// queue parts the input side from the sequencer, and a registered output lets the
// sequencer start on the next word while a result still waits. a word inside a
// keystream block passes idle and emit; one opening a new block also passes load,
// 20 rounds (one round per cycle in the round unit) and final; a first byte adds 14
// hash steps before load. reset empties the queue and the output register, clears
// counter, nonce, position and keys. when m_tready is low the result holds, the
// sequencer waits at its next output and the queue fills, then s_tready drops.
module tcp_seq_chacha20_stream_xor_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // data_byte, src_addr, dst_addr, src_port, dst_port, protocol, seq_number
    input  logic [143:0]  s_tdata,
    // first
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_byte
    output logic [7:0]    m_tdata,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    tcsc_pkg::key_t   key_reg;
    tcsc_pkg::item_t  in_item;
    tcsc_pkg::item_t  head_item;
    tcsc_pkg::qstat_t qstat;
    logic             pop;

    assign in_item.data_byte  = s_tdata[7:0];
    assign in_item.first      = s_tuser;
    assign in_item.src_addr   = s_tdata[39:8];
    assign in_item.dst_addr   = s_tdata[71:40];
    assign in_item.src_port   = s_tdata[87:72];
    assign in_item.dst_port   = s_tdata[103:88];
    assign in_item.protocol   = s_tdata[111:104];
    assign in_item.seq_number = s_tdata[143:112];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcsc_pkg::REG_KEY_0_1: key_reg[0] <= cfg_data;
                tcsc_pkg::REG_KEY_2_3: key_reg[1] <= cfg_data;
                tcsc_pkg::REG_KEY_4_5: key_reg[2] <= cfg_data;
                tcsc_pkg::REG_KEY_6_7: key_reg[3] <= cfg_data;
                default: key_reg <= key_reg;
            endcase
        end
    end

    tcsc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .in_ready  (s_tready),
        .pop       (pop),
        .head_item (head_item),
        .stat      (qstat)
    );

    tcsc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .qstat     (qstat),
        .head_item (head_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_ready (m_tready)
    );

`ifndef SYNTHESIS
    a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= tcsc_pkg::QCNT_W'(tcsc_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("sequencer took a word from an empty queue");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !s_tready)
        else $error("input ready while queue full");
`endif

endmodule
